// ===== design/tcch_pkg.sv =====
// Shared types and constants for the terminal control character handler.
// No dependencies.
package tcch_pkg;

    localparam logic [1:0] KIND_DRAW   = 2'd0;
    localparam logic [1:0] KIND_BEEP   = 2'd1;
    localparam logic [1:0] KIND_SCROLL = 2'd2;
    localparam logic [1:0] KIND_ESCB   = 2'd3;

    localparam logic [2:0] CFG_WRAP_LIMIT    = 3'd0;
    localparam logic [2:0] CFG_BOTTOM_ROW    = 3'd1;
    localparam logic [2:0] CFG_REGION_TOP    = 3'd2;
    localparam logic [2:0] CFG_REGION_BOTTOM = 3'd3;
    localparam logic [2:0] CFG_DRAW_MASK     = 3'd4;

    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_HT  = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;

    localparam logic [7:0] TAB_MASK   = 8'hF8;
    localparam logic [7:0] SEQ_MAX    = 8'hFF;

    localparam logic [7:0]  RST_WRAP_LIMIT    = 8'd80;
    localparam logic [5:0]  RST_BOTTOM_ROW    = 6'd23;
    localparam logic [5:0]  RST_REGION_TOP    = 6'd0;
    localparam logic [5:0]  RST_REGION_BOTTOM = 6'd23;
    localparam logic [15:0] RST_DRAW_MASK     = 16'd0;

    localparam int RESULT_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  wrap_limit;
        logic [5:0]  bottom_row;
        logic [5:0]  region_top;
        logic [5:0]  region_bottom;
        logic [15:0] draw_mask;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  glyph;
        logic [8:0]  column;
        logic [5:0]  row;
        logic [7:0]  seq_index;
        logic        seq_last;
        logic [15:0] mask_out;
        logic [5:0]  scroll_top;
        logic [5:0]  scroll_bottom;
    } result_t;

endpackage

// ===== design/tcch_core.sv =====
// Per-byte decode: cursor, row and escape count registers plus the logic
// that turns one byte into zero, one or two results. Depends on tcch_pkg.
module tcch_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            char_code,
    input  tcch_pkg::cfg_t        cfg,
    output tcch_pkg::result_t     res0,
    output tcch_pkg::result_t     res1,
    output logic [1:0]            res_cnt
);

    logic [8:0] col_reg, col_next;
    logic [5:0] row_reg, row_next;
    logic [7:0] esc_reg, esc_next;

    always_comb
    begin
        tcch_pkg::result_t scroll_r;
        tcch_pkg::result_t draw_r;
        logic [6:0]        row_inc;
        logic              lf_scroll;
        logic [5:0]        row_lf;
        logic              wrap;
        logic [8:0]        col_d;
        logic [5:0]        row_d;
        logic              ends;

        col_next = col_reg;
        row_next = row_reg;
        esc_next = esc_reg;
        res0     = '0;
        res1     = '0;
        res_cnt  = 2'd0;

        row_inc   = {1'b0, row_reg} + 7'd1;
        lf_scroll = row_inc > {1'b0, cfg.bottom_row};
        row_lf    = lf_scroll ? cfg.bottom_row : row_inc[5:0];

        scroll_r               = '0;
        scroll_r.kind          = tcch_pkg::KIND_SCROLL;
        scroll_r.scroll_top    = cfg.region_top;
        scroll_r.scroll_bottom = cfg.region_bottom;

        wrap  = col_reg > {1'b0, cfg.wrap_limit};
        col_d = wrap ? 9'd0 : col_reg;
        row_d = wrap ? row_lf : row_reg;

        draw_r          = '0;
        draw_r.kind     = tcch_pkg::KIND_DRAW;
        draw_r.glyph    = char_code;
        draw_r.column   = col_d;
        draw_r.row      = row_d;
        draw_r.mask_out = cfg.draw_mask;

        ends = char_code inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h7E, 8'h3D, 8'h3E};

        if (esc_reg != 8'd0)
        begin
            res0.kind      = tcch_pkg::KIND_ESCB;
            res0.glyph     = char_code;
            res0.seq_index = esc_reg;
            res0.seq_last  = ends;
            res_cnt        = 2'd1;
            if (ends)
                esc_next = 8'd0;
            else if (esc_reg != tcch_pkg::SEQ_MAX)
                esc_next = esc_reg + 8'd1;
        end
        else
        begin
            case (char_code)
                tcch_pkg::CH_BEL:
                begin
                    res0.kind = tcch_pkg::KIND_BEEP;
                    res_cnt   = 2'd1;
                end
                tcch_pkg::CH_BS:
                begin
                    if (col_reg != 9'd0)
                        col_next = col_reg - 9'd1;
                end
                tcch_pkg::CH_HT:
                begin
                    col_next = {1'b0, col_reg[7:0] & tcch_pkg::TAB_MASK} + 9'd8;
                end
                tcch_pkg::CH_LF:
                begin
                    row_next = row_lf;
                    if (lf_scroll)
                    begin
                        res0    = scroll_r;
                        res_cnt = 2'd1;
                    end
                end
                tcch_pkg::CH_CR:
                begin
                    col_next = 9'd0;
                end
                tcch_pkg::CH_ESC:
                begin
                    res0.kind  = tcch_pkg::KIND_ESCB;
                    res0.glyph = tcch_pkg::CH_ESC;
                    res_cnt    = 2'd1;
                    esc_next   = 8'd1;
                end
                default:
                begin
                    if (char_code inside {[8'h20:8'h7E]})
                    begin
                        col_next = col_d + 9'd1;
                        row_next = row_d;
                        if (wrap && lf_scroll)
                        begin
                            res0    = scroll_r;
                            res1    = draw_r;
                            res_cnt = 2'd2;
                        end
                        else
                        begin
                            res0    = draw_r;
                            res_cnt = 2'd1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 9'd0;
            row_reg <= 6'd0;
            esc_reg <= 8'd0;
        end
        else if (fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            esc_reg <= esc_next;
        end
    end

endmodule

// ===== design/tcch_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one beat a cycle
// while out_ready is high. Depends on tcch_pkg.
module tcch_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_cnt,
    input  tcch_pkg::result_t  push0,
    input  tcch_pkg::result_t  push1,
    output logic               room2,
    output logic               out_valid,
    input  logic               out_ready,
    output tcch_pkg::result_t  out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    tcch_pkg::result_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr1;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;

    assign wr_ptr1   = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room2     = cnt_reg <= CW'(DEPTH - 2);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr1;
            2'd2:    wr_ptr_next = (wr_ptr1 == LAST) ? '0 : wr_ptr1 + AW'(1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        cnt_next = cnt_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== design/terminal_control_char_handler.sv =====
// Terminal control character handler, top level: input register, config
// registers, byte decode and result queue. Depends on tcch_pkg, tcch_core, tcch_fifo.
//
// Usage: bytes of the terminal output stream enter on s_axis, one per beat
// (tdata = byte, tlast = end of a write call, carried but unused). Results
// leave on m_axis: tuser is the kind (draw, beep, scroll, escape byte), tdata
// the remaining fields. Config registers are written on cfg_we/cfg_index/cfg_data;
// the user must write them only while no byte is in flight; the block does not check.
// Flow: an accepted byte is held in the input register and decoded combinationally;
// once the result queue has room for two results, its results are written there
// and the first one is then valid on m_axis.
// Throughput: one byte per cycle while two queue entries are free; a byte that wraps
// past the bottom row gives a scroll and a draw and so needs two output beats, which
// the four-entry result queue absorbs. Bytes that give no result leave no beat.
// Reset: cursor column, row and escape count go to zero, registers to their
// defaults (wrap 80, bottom row 23, region 0..23, mask 0), queue empties.
// Stall: when m_axis_tready is low the queue fills; once fewer than two
// entries are free the decode holds its byte and s_axis_tready drops.
module terminal_control_char_handler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // chunk_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] glyph, [16:8] column, [22:17] row, [30:23] seq_index, [31] seq_last,
    // [47:32] mask_out, [53:48] scroll_top, [59:54] scroll_bottom, [63:60] zero
    output logic [63:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    tcch_pkg::cfg_t    cfg_reg;
    tcch_pkg::result_t res0, res1, head;
    logic [1:0]        res_cnt, push_cnt;
    logic              room2, fire;
    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic              in_last_reg;

    assign fire          = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || room2;
    assign push_cnt      = fire ? res_cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // chunk_end rides along with the byte; it does not change decoding
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wrap_limit    <= tcch_pkg::RST_WRAP_LIMIT;
            cfg_reg.bottom_row    <= tcch_pkg::RST_BOTTOM_ROW;
            cfg_reg.region_top    <= tcch_pkg::RST_REGION_TOP;
            cfg_reg.region_bottom <= tcch_pkg::RST_REGION_BOTTOM;
            cfg_reg.draw_mask     <= tcch_pkg::RST_DRAW_MASK;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcch_pkg::CFG_WRAP_LIMIT:    cfg_reg.wrap_limit    <= cfg_data[7:0];
                tcch_pkg::CFG_BOTTOM_ROW:    cfg_reg.bottom_row    <= cfg_data[5:0];
                tcch_pkg::CFG_REGION_TOP:    cfg_reg.region_top    <= cfg_data[5:0];
                tcch_pkg::CFG_REGION_BOTTOM: cfg_reg.region_bottom <= cfg_data[5:0];
                tcch_pkg::CFG_DRAW_MASK:     cfg_reg.draw_mask     <= cfg_data;
                default:                     ;
            endcase
        end
    end

    tcch_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_code (in_char_reg),
        .cfg       (cfg_reg),
        .res0      (res0),
        .res1      (res1),
        .res_cnt   (res_cnt)
    );

    tcch_fifo #(.DEPTH(tcch_pkg::RESULT_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tuser = head.kind;
    assign m_axis_tdata = {4'd0, head.scroll_bottom, head.scroll_top, head.mask_out,
                           head.seq_last, head.seq_index, head.row, head.column,
                           head.glyph};

endmodule

// ===== tb/tb_terminal_control_char_handler.sv =====
// Testbench for terminal_control_char_handler: streams terminal bytes on s_axis and checks
// every m_axis beat against a cursor / escape-sequence predictor kept in the bench.
// Depends on tcch_pkg and the RTL top level only.
module tb_terminal_control_char_handler;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 120;
    localparam int PHASE_ITEMS    = 85;
    localparam int NUM_PHASES     = 8;
    localparam int LONG_SEQ_LEN   = 300;

    typedef struct packed {
        logic [7:0]        ch;
        logic              lst;
        logic              typed;
        tcch_pkg::result_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    always #4 clk = ~clk;

    terminal_control_char_handler i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tcch_pkg::cfg_t    shadow;
    logic [8:0]        cur_col = '0;
    logic [5:0]        cur_row = '0;
    logic [7:0]        esc_idx = '0;
    tcch_pkg::result_t new_cmds[$];
    tcch_pkg::result_t cmd_q[$];
    int                errors = 0;
    int                tx_gap_max = 6;
    int                rx_gap_max = 6;
    int                hold_len = 0;

    dir_row_t dir_rows [0:27] = '{
        '{8'h41, 1'b0, 1'b1, '{tcch_pkg::KIND_DRAW, 8'h41, 9'd0, 6'd0, 8'd0, 1'b0, 16'd0,
          6'd0, 6'd0}},
        '{tcch_pkg::CH_BEL, 1'b1, 1'b1, '{tcch_pkg::KIND_BEEP, 8'd0, 9'd0, 6'd0, 8'd0, 1'b0,
          16'd0, 6'd0, 6'd0}},
        '{tcch_pkg::CH_BS, 1'b0, 1'b0, '0},
        '{tcch_pkg::CH_BS, 1'b0, 1'b0, '0},
        '{8'h20, 1'b0, 1'b1, '{tcch_pkg::KIND_DRAW, 8'h20, 9'd0, 6'd0, 8'd0, 1'b0, 16'd0,
          6'd0, 6'd0}},
        '{8'h7E, 1'b0, 1'b0, '0},
        '{tcch_pkg::CH_HT, 1'b0, 1'b0, '0},
        '{8'h7E, 1'b1, 1'b0, '0},
        '{tcch_pkg::CH_LF, 1'b0, 1'b0, '0},
        '{tcch_pkg::CH_CR, 1'b1, 1'b0, '0},
        '{tcch_pkg::CH_ESC, 1'b0, 1'b1, '{tcch_pkg::KIND_ESCB, tcch_pkg::CH_ESC, 9'd0, 6'd0,
          8'd0, 1'b0, 16'd0, 6'd0, 6'd0}},
        '{8'h5B, 1'b0, 1'b1, '{tcch_pkg::KIND_ESCB, 8'h5B, 9'd0, 6'd0, 8'd1, 1'b0, 16'd0,
          6'd0, 6'd0}},
        '{8'h31, 1'b0, 1'b1, '{tcch_pkg::KIND_ESCB, 8'h31, 9'd0, 6'd0, 8'd2, 1'b0, 16'd0,
          6'd0, 6'd0}},
        '{8'h7E, 1'b1, 1'b1, '{tcch_pkg::KIND_ESCB, 8'h7E, 9'd0, 6'd0, 8'd3, 1'b1, 16'd0,
          6'd0, 6'd0}},
        '{tcch_pkg::CH_ESC, 1'b0, 1'b1, '{tcch_pkg::KIND_ESCB, tcch_pkg::CH_ESC, 9'd0, 6'd0,
          8'd0, 1'b0, 16'd0, 6'd0, 6'd0}},
        '{8'h3D, 1'b0, 1'b1, '{tcch_pkg::KIND_ESCB, 8'h3D, 9'd0, 6'd0, 8'd1, 1'b1, 16'd0,
          6'd0, 6'd0}},
        '{tcch_pkg::CH_ESC, 1'b0, 1'b1, '{tcch_pkg::KIND_ESCB, tcch_pkg::CH_ESC, 9'd0, 6'd0,
          8'd0, 1'b0, 16'd0, 6'd0, 6'd0}},
        '{8'h3E, 1'b1, 1'b1, '{tcch_pkg::KIND_ESCB, 8'h3E, 9'd0, 6'd0, 8'd1, 1'b1, 16'd0,
          6'd0, 6'd0}},
        '{tcch_pkg::CH_ESC, 1'b0, 1'b1, '{tcch_pkg::KIND_ESCB, tcch_pkg::CH_ESC, 9'd0, 6'd0,
          8'd0, 1'b0, 16'd0, 6'd0, 6'd0}},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h7A, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h1F, 1'b0, 1'b0, '0},
        '{8'h20, 1'b1, 1'b0, '0}
    };

    function automatic bit is_seq_end(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)
            || b == 8'h7E || b == 8'h3D || b == 8'h3E;
    endfunction

    function automatic logic [7:0] seq_body();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_seq_end(b));
        return b;
    endfunction

    function automatic logic [7:0] seq_terminator();
        logic [7:0] b;
        do
            b = 8'($urandom_range(8'h3D, 8'h7E));
        while (!is_seq_end(b));
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // line feed: past the bottom row emits a scroll and clamps
    task automatic next_row();
        logic [6:0]        nr;
        tcch_pkg::result_t c;
        nr = {1'b0, cur_row} + 7'd1;
        if (nr > {1'b0, shadow.bottom_row})
        begin
            c = '0;
            c.kind = tcch_pkg::KIND_SCROLL;
            c.scroll_top = shadow.region_top;
            c.scroll_bottom = shadow.region_bottom;
            new_cmds.push_back(c);
            cur_row = shadow.bottom_row;
        end
        else
        begin
            cur_row = nr[5:0];
        end
    endtask

    task automatic apply_byte(input logic [7:0] b);
        tcch_pkg::result_t c;
        c = '0;
        if (esc_idx != 8'd0)
        begin
            c.kind = tcch_pkg::KIND_ESCB;
            c.glyph = b;
            c.seq_index = esc_idx;
            c.seq_last = is_seq_end(b);
            new_cmds.push_back(c);
            if (c.seq_last)
                esc_idx = 8'd0;
            else if (esc_idx != tcch_pkg::SEQ_MAX)
                esc_idx = esc_idx + 8'd1;
        end
        else
        begin
            case (b)
                tcch_pkg::CH_BEL:
                begin
                    c.kind = tcch_pkg::KIND_BEEP;
                    new_cmds.push_back(c);
                end
                tcch_pkg::CH_BS:
                begin
                    if (cur_col != 9'd0)
                        cur_col = cur_col - 9'd1;
                end
                tcch_pkg::CH_HT:  cur_col = {1'b0, cur_col[7:0] & tcch_pkg::TAB_MASK} + 9'd8;
                tcch_pkg::CH_LF:  next_row();
                tcch_pkg::CH_CR:  cur_col = '0;
                tcch_pkg::CH_ESC:
                begin
                    c.kind = tcch_pkg::KIND_ESCB;
                    c.glyph = tcch_pkg::CH_ESC;
                    new_cmds.push_back(c);
                    esc_idx = 8'd1;
                end
                default:
                begin
                    if (b >= 8'h20 && b <= 8'h7E)
                    begin
                        if (cur_col > {1'b0, shadow.wrap_limit})
                        begin
                            cur_col = '0;
                            next_row();
                        end
                        c.kind = tcch_pkg::KIND_DRAW;
                        c.glyph = b;
                        c.column = cur_col;
                        c.row = cur_row;
                        c.mask_out = shadow.draw_mask;
                        new_cmds.push_back(c);
                        cur_col = cur_col + 9'd1;
                    end
                end
            endcase
        end
    endtask

    // offer one byte; a typed row replaces the predicted commands
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                             input tcch_pkg::result_t want);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= lst;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        apply_byte(b);
        if (typed)
        begin
            new_cmds.delete();
            cmd_q.push_back(want);
        end
        else
        begin
            while (new_cmds.size() != 0)
                cmd_q.push_back(new_cmds.pop_front());
        end
    endtask

    task automatic send(input logic [7:0] b);
        send_byte(b, 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            tcch_pkg::CFG_WRAP_LIMIT:    shadow.wrap_limit = val[7:0];
            tcch_pkg::CFG_BOTTOM_ROW:    shadow.bottom_row = val[5:0];
            tcch_pkg::CFG_REGION_TOP:    shadow.region_top = val[5:0];
            tcch_pkg::CFG_REGION_BOTTOM: shadow.region_bottom = val[5:0];
            tcch_pkg::CFG_DRAW_MASK:     shadow.draw_mask = val;
            default: ;
        endcase
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (cmd_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly printables, controls and short escape sequences, some noise
    task automatic gen_traffic(input int n_items);
        int         made;
        int         r;
        int         k;
        logic [7:0] b;
        made = 0;
        while (made < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                send(8'($urandom_range(8'h20, 8'h7E)));
                made++;
            end
            else if (r < 65)
            begin
                case ($urandom_range(0, 4))
                    0:       b = tcch_pkg::CH_BEL;
                    1:       b = tcch_pkg::CH_BS;
                    2:       b = tcch_pkg::CH_HT;
                    3:       b = tcch_pkg::CH_LF;
                    default: b = tcch_pkg::CH_CR;
                endcase
                send(b);
                made++;
            end
            else if (r < 88)
            begin
                send(tcch_pkg::CH_ESC);
                k = $urandom_range(0, 4);
                repeat (k) send(seq_body());
                made += k + 1;
                if ($urandom_range(0, 7) != 0)
                begin
                    send(seq_terminator());
                    made++;
                end
            end
            else
            begin
                send(8'($urandom_range(0, 255)));
                made++;
            end
        end
    endtask

    initial
    begin : result_monitor
        int                stall;
        tcch_pkg::result_t want;
        logic [63:0]       d;
        logic [1:0]        k;
        forever
        begin
            if (hold_len > 0)
            begin
                stall = hold_len;
                hold_len = 0;
            end
            else
            begin
                stall = $urandom_range(0, rx_gap_max);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            d = m_axis_tdata;
            k = m_axis_tuser;
            if (cmd_q.size() == 0)
            begin
                report_mismatch($sformatf("beat with nothing expected, kind %0d data 0x%0h", k, d));
            end
            else
            begin
                want = cmd_q.pop_front();
                cmp_field("kind", 16'(k), 16'(want.kind));
                cmp_field("glyph", 16'(d[7:0]), 16'(want.glyph));
                cmp_field("column", 16'(d[16:8]), 16'(want.column));
                cmp_field("row", 16'(d[22:17]), 16'(want.row));
                cmp_field("seq_index", 16'(d[30:23]), 16'(want.seq_index));
                cmp_field("seq_last", 16'(d[31]), 16'(want.seq_last));
                cmp_field("mask_out", d[47:32], want.mask_out);
                cmp_field("scroll_top", 16'(d[53:48]), 16'(want.scroll_top));
                cmp_field("scroll_bottom", 16'(d[59:54]), 16'(want.scroll_bottom));
                cmp_field("pad", 16'(d[63:60]), 16'd0);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
                || (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL terminal_control_char_handler");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] wdat;
        shadow.wrap_limit = tcch_pkg::RST_WRAP_LIMIT;
        shadow.bottom_row = tcch_pkg::RST_BOTTOM_ROW;
        shadow.region_top = tcch_pkg::RST_REGION_TOP;
        shadow.region_bottom = tcch_pkg::RST_REGION_BOTTOM;
        shadow.draw_mask = tcch_pkg::RST_DRAW_MASK;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].ch, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    write_reg(tcch_pkg::CFG_WRAP_LIMIT, 16'hFFFF);
                    write_reg(tcch_pkg::CFG_BOTTOM_ROW, 16'hFFFF);
                    write_reg(tcch_pkg::CFG_REGION_TOP, 16'hFFFF);
                    write_reg(tcch_pkg::CFG_REGION_BOTTOM, 16'hFFFF);
                    write_reg(tcch_pkg::CFG_DRAW_MASK, 16'hFFFF);
                    tx_gap_max = 6;
                    rx_gap_max = 6;
                end
                1:
                begin
                    write_reg(tcch_pkg::CFG_WRAP_LIMIT, 16'd1);
                    write_reg(tcch_pkg::CFG_BOTTOM_ROW, 16'd1);
                    write_reg(tcch_pkg::CFG_REGION_TOP, 16'd0);
                    write_reg(tcch_pkg::CFG_REGION_BOTTOM, 16'd0);
                    write_reg(tcch_pkg::CFG_DRAW_MASK, 16'd0);
                    tx_gap_max = 0;
                    rx_gap_max = 0;
                end
                2:
                begin
                    write_reg(tcch_pkg::CFG_WRAP_LIMIT, 16'd0);
                    write_reg(tcch_pkg::CFG_BOTTOM_ROW, 16'd0);
                    write_reg(tcch_pkg::CFG_REGION_TOP, 16'($urandom));
                    write_reg(tcch_pkg::CFG_REGION_BOTTOM, 16'($urandom));
                    write_reg(tcch_pkg::CFG_DRAW_MASK, 16'($urandom));
                    tx_gap_max = 0;
                    rx_gap_max = 6;
                end
                3:
                begin
                    write_reg(tcch_pkg::CFG_WRAP_LIMIT, 16'(tcch_pkg::RST_WRAP_LIMIT));
                    write_reg(tcch_pkg::CFG_BOTTOM_ROW, 16'(tcch_pkg::RST_BOTTOM_ROW));
                    write_reg(tcch_pkg::CFG_REGION_TOP, 16'(tcch_pkg::RST_REGION_TOP));
                    write_reg(tcch_pkg::CFG_REGION_BOTTOM, 16'(tcch_pkg::RST_REGION_BOTTOM));
                    write_reg(tcch_pkg::CFG_DRAW_MASK, 16'($urandom));
                    tx_gap_max = 6;
                    rx_gap_max = 0;
                end
                default:
                begin
                    wdat = 16'($urandom);
                    if ($urandom_range(0, 2) != 0)
                        wdat[7:0] = 8'($urandom_range(0, 12));
                    write_reg(tcch_pkg::CFG_WRAP_LIMIT, wdat);
                    wdat = 16'($urandom);
                    if ($urandom_range(0, 2) != 0)
                        wdat[5:0] = 6'($urandom_range(0, 6));
                    write_reg(tcch_pkg::CFG_BOTTOM_ROW, wdat);
                    write_reg(tcch_pkg::CFG_REGION_TOP, 16'($urandom));
                    write_reg(tcch_pkg::CFG_REGION_BOTTOM, 16'($urandom));
                    write_reg(tcch_pkg::CFG_DRAW_MASK, 16'($urandom));
                    if (ph == 4)
                    begin
                        for (int idx = int'(tcch_pkg::CFG_DRAW_MASK) + 1;
                             idx < 2 ** $bits(cfg_index); idx++)
                            write_reg(3'(idx), 16'($urandom));
                    end
                    tx_gap_max = 6 * $urandom_range(0, 1);
                    rx_gap_max = 6 * $urandom_range(0, 1);
                end
            endcase
            cfg_we <= 1'b0;

            case (ph)
                0:
                begin
                    // bottom row scroll, then column 256, wrap and tab from 256
                    repeat (64) send(tcch_pkg::CH_LF);
                    send(tcch_pkg::CH_CR);
                    repeat (32) send(tcch_pkg::CH_HT);
                    send(tcch_pkg::CH_BS);
                    send(8'h61);
                    send(8'h62);
                    send(tcch_pkg::CH_CR);
                    repeat (33) send(tcch_pkg::CH_HT);
                end
                2:
                begin
                    hold_len = HOLD_CYCLES;
                end
                3:
                begin
                    // sequence long enough to saturate the index
                    send(tcch_pkg::CH_ESC);
                    repeat (LONG_SEQ_LEN) send(seq_body());
                    send(seq_terminator());
                end
                default: ;
            endcase
            gen_traffic(PHASE_ITEMS);
        end

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS terminal_control_char_handler");
        else
            $display("FAIL terminal_control_char_handler");
        $finish;
    end

endmodule
